// File: rtl/ilid_pkg.sv
package ilid_pkg;

   localparam int OP_W           = 3;
   localparam int POS_W          = 11;
   localparam int VALUE_W        = 32;
   localparam int LEN_W          = 11;
   localparam int CAPACITY_DFLT  = 1024;

   // packed item widths, rounded up to whole bytes
   localparam int REQ_DATA_W     = 48;
   localparam int RSP_DATA_W     = 48;

   typedef enum logic [OP_W-1:0] {
      OP_GET    = 3'd0,
      OP_HEAD   = 3'd1,
      OP_TAIL   = 3'd2,
      OP_INSERT = 3'd3,
      OP_DELETE = 3'd4
   } op_type;

endpackage

// File: rtl/indexed_list_insert_delete.sv
// Ordered list of signed 32-bit values, up to CAPACITY entries, with indexed
// get, add at head, add at tail, insert before position and delete at position.
// Channels: req_* takes one item per operation (op, position, value); rsp_*
// returns exactly one item per request (read_value, ok, length), in order.
// A request is taken only while no earlier request is in progress.
// After acceptance, every request ends in S_FINISH, which places its result in
// the output register. A get hit first reads the memory in S_READ; an insert
// that is not an append moves entries in S_SHIFT and then writes the new value
// in S_FILL; a delete that is not at the tail moves entries in S_SHIFT. A get
// miss, a rejected request, an append and a tail delete go straight to S_FINISH.
// The entries sit in one single-port-write, single-port-read memory with a
// registered read; an insert or delete moves one entry per cycle through it,
// so the longest operations are those near the head of a nearly full list.
// Reset clears the entry count and all handshake state; the memory itself is
// not cleared, since only entries below the count are ever read.
// When the receiver stalls, the result waits in the output register and the
// block accepts the next item; that item's result then waits until the output
// register is free.
module indexed_list_insert_delete #(
   parameter int CAPACITY = ilid_pkg::CAPACITY_DFLT
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   // [2:0] op, [13:3] position, [45:14] value, [47:46] zero
   input  logic [ilid_pkg::REQ_DATA_W-1:0] req_tdata,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // [31:0] read_value, [32] ok, [43:33] length, [47:44] zero
   output logic [ilid_pkg::RSP_DATA_W-1:0] rsp_tdata
);

   localparam int AW   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CW   = $clog2(CAPACITY + 1);
   // common width for comparing positions against the count
   localparam int CMPW = (CW > ilid_pkg::POS_W) ? CW : ilid_pkg::POS_W;
   localparam int VW   = ilid_pkg::VALUE_W;

   typedef enum logic [4:0] {
      S_IDLE   = 5'b00001,
      S_READ   = 5'b00010,
      S_SHIFT  = 5'b00100,
      S_FILL   = 5'b01000,
      S_FINISH = 5'b10000
   } state_type;

   state_type         state_ff,  state_in;
   logic [CW-1:0]     count_ff,  count_in;
   logic [CMPW-1:0]   idx_ff,    idx_in;
   logic [CMPW-1:0]   tgt_ff,    tgt_in;
   logic              is_del_ff, is_del_in;
   logic [VW-1:0]     val_ff,    val_in;
   logic [VW-1:0]     res_val_ff, res_val_in;
   logic              res_ok_ff, res_ok_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [ilid_pkg::RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;

   logic              wr_en;
   logic [AW-1:0]     wr_addr;
   logic [VW-1:0]     wr_data;
   logic              rd_en;
   logic [AW-1:0]     rd_addr;
   logic [VW-1:0]     rd_data;

   ilid_pkg::op_type  req_op;
   logic [CMPW-1:0]   req_pos;
   logic [VW-1:0]     req_val;
   logic [CMPW-1:0]   cnt_ext;
   logic [CMPW-1:0]   cnt_m1;
   logic [CMPW-1:0]   pos_p1;
   logic [CMPW-1:0]   idx_p1;
   logic [CMPW-1:0]   idx_m1;
   logic [CMPW-1:0]   ins_pos;
   logic              full;
   logic              accept;
   logic              out_free;

   assign req_op   = ilid_pkg::op_type'(req_tdata[2:0]);
   assign req_pos  = CMPW'(req_tdata[13:3]);
   assign req_val  = req_tdata[45:14];
   assign cnt_ext  = CMPW'(count_ff);
   assign cnt_m1   = cnt_ext - CMPW'(1);
   assign pos_p1   = req_pos + CMPW'(1);
   assign idx_p1   = idx_ff + CMPW'(1);
   assign idx_m1   = idx_ff - CMPW'(1);
   assign full     = (cnt_ext == CMPW'(CAPACITY));

   assign req_tready = (state_ff == S_IDLE);
   assign accept     = req_tvalid && req_tready;
   assign out_free   = !rsp_valid_ff || rsp_tready;

   // insertion point per add flavor
   always_comb begin
      case (req_op)
         ilid_pkg::OP_HEAD: ins_pos = '0;
         ilid_pkg::OP_TAIL: ins_pos = cnt_ext;
         default:           ins_pos = req_pos;
      endcase
   end

   ilid_ram #(
      .DEPTH (CAPACITY),
      .WIDTH (VW)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      idx_in       = idx_ff;
      tgt_in       = tgt_ff;
      is_del_in    = is_del_ff;
      val_in       = val_ff;
      res_val_in   = res_val_ff;
      res_ok_in    = res_ok_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      wr_en        = 1'b0;
      wr_addr      = '0;
      wr_data      = val_ff;
      rd_en        = 1'b0;
      rd_addr      = '0;

      // drain the output register
      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               val_in     = req_val;
               res_val_in = '0;
               res_ok_in  = 1'b0;
               state_in   = S_FINISH;
               case (req_op)
                  ilid_pkg::OP_GET: begin
                     if (req_pos < cnt_ext) begin
                        rd_en    = 1'b1;
                        rd_addr  = req_pos[AW-1:0];
                        state_in = S_READ;
                     end else begin
                        res_val_in = '1;
                     end
                  end
                  ilid_pkg::OP_HEAD, ilid_pkg::OP_TAIL, ilid_pkg::OP_INSERT: begin
                     if (!full && ins_pos <= cnt_ext) begin
                        if (ins_pos == cnt_ext) begin
                           // append: no entries move
                           wr_en     = 1'b1;
                           wr_addr   = ins_pos[AW-1:0];
                           wr_data   = req_val;
                           count_in  = count_ff + CW'(1);
                           res_ok_in = 1'b1;
                        end else begin
                           // move entries up, starting at the tail
                           rd_en     = 1'b1;
                           rd_addr   = cnt_m1[AW-1:0];
                           idx_in    = cnt_m1;
                           tgt_in    = ins_pos;
                           is_del_in = 1'b0;
                           state_in  = S_SHIFT;
                        end
                     end
                  end
                  ilid_pkg::OP_DELETE: begin
                     if (req_pos < cnt_ext) begin
                        if (req_pos == cnt_m1) begin
                           count_in  = count_ff - CW'(1);
                           res_ok_in = 1'b1;
                        end else begin
                           // move entries down, starting just past the gap
                           rd_en     = 1'b1;
                           rd_addr   = pos_p1[AW-1:0];
                           idx_in    = pos_p1;
                           is_del_in = 1'b1;
                           state_in  = S_SHIFT;
                        end
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end

         S_READ: begin
            res_val_in = rd_data;
            res_ok_in  = 1'b1;
            state_in   = S_FINISH;
         end

         S_SHIFT: begin
            // rd_data holds the entry at idx_ff
            wr_en   = 1'b1;
            wr_data = rd_data;
            if (is_del_ff) begin
               wr_addr = idx_m1[AW-1:0];
               if (idx_ff == cnt_m1) begin
                  count_in  = count_ff - CW'(1);
                  res_ok_in = 1'b1;
                  state_in  = S_FINISH;
               end else begin
                  rd_en   = 1'b1;
                  rd_addr = idx_p1[AW-1:0];
                  idx_in  = idx_p1;
               end
            end else begin
               wr_addr = idx_p1[AW-1:0];
               if (idx_ff == tgt_ff) begin
                  state_in = S_FILL;
               end else begin
                  rd_en   = 1'b1;
                  rd_addr = idx_m1[AW-1:0];
                  idx_in  = idx_m1;
               end
            end
         end

         S_FILL: begin
            wr_en     = 1'b1;
            wr_addr   = tgt_ff[AW-1:0];
            wr_data   = val_ff;
            count_in  = count_ff + CW'(1);
            res_ok_in = 1'b1;
            state_in  = S_FINISH;
         end

         S_FINISH: begin
            // hold the result until the output register is free
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {4'b0000, ilid_pkg::LEN_W'(count_ff), res_ok_ff, res_val_ff};
               state_in     = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff      <= idx_in;
      tgt_ff      <= tgt_in;
      is_del_ff   <= is_del_in;
      val_ff      <= val_in;
      res_val_ff  <= res_val_in;
      res_ok_ff   <= res_ok_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // the count never passes the capacity
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ext <= CMPW'(CAPACITY))
      else $error("entry count above capacity");

   // every memory write lands at or below the current count
   a_write_range: assert property (@(posedge clock) disable iff (reset)
      wr_en |-> CMPW'(wr_addr) <= cnt_ext)
      else $error("memory write beyond the list");

   // the count moves by at most one per cycle
   a_count_step: assert property (@(posedge clock) disable iff (reset)
      !$past(reset) |-> (count_ff == $past(count_ff))
                     || (count_ff == $past(count_ff) + CW'(1))
                     || (count_ff + CW'(1) == $past(count_ff)))
      else $error("entry count jumped");

   // a finished item reaches the output once the register is free
   a_finish_out: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_FINISH && out_free) |=> rsp_tvalid && state_ff == S_IDLE)
      else $error("finished item not presented");

endmodule

// File: rtl/ilid_ram.sv
module ilid_ram #(
   parameter int DEPTH = ilid_pkg::CAPACITY_DFLT,
   parameter int WIDTH = ilid_pkg::VALUE_W,
   localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: sim/list_op_check.sv
module list_op_check (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   input  logic                            req_tready,
   // [2:0] op, [13:3] position, [45:14] value, [47:46] zero
   input  logic [ilid_pkg::REQ_DATA_W-1:0] req_tdata,
   input  logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // [31:0] read_value, [32] ok, [43:33] length, [47:44] zero
   input  logic [ilid_pkg::RSP_DATA_W-1:0] rsp_tdata,
   output int unsigned                     mismatches,
   output int unsigned                     outstanding
);

   localparam int OP_W          = ilid_pkg::OP_W;
   localparam int POS_W         = ilid_pkg::POS_W;
   localparam int VALUE_W       = ilid_pkg::VALUE_W;
   localparam int LEN_W         = ilid_pkg::LEN_W;
   localparam int LIST_CAPACITY = ilid_pkg::CAPACITY_DFLT;
   localparam int REPORT_LIMIT  = 10;
   localparam logic [VALUE_W-1:0] MISS_VALUE = '1;

   typedef struct packed {
      logic [VALUE_W-1:0] read_value;
      logic               ok;
      logic [LEN_W-1:0]   length;
   } list_result_type;

   logic [VALUE_W-1:0] shadow_entries [LIST_CAPACITY];
   int unsigned        shadow_count;
   list_result_type    pending_results [$];
   int unsigned        fail_tally;

   // Apply one operation to the shadow list and return the result it gives.
   task automatic apply_list_op(input logic [OP_W-1:0] op, input logic [POS_W-1:0] pos,
                                input logic [VALUE_W-1:0] val,
                                output list_result_type res);
      int unsigned slot;
      int unsigned i;
      res = '0;
      case (op)
         ilid_pkg::OP_GET: begin
            if (pos < shadow_count) begin
               res.read_value = shadow_entries[pos];
               res.ok         = 1'b1;
            end else begin
               res.read_value = MISS_VALUE;
            end
         end
         ilid_pkg::OP_HEAD, ilid_pkg::OP_TAIL, ilid_pkg::OP_INSERT: begin
            slot = (op == ilid_pkg::OP_HEAD) ? 0 :
                   (op == ilid_pkg::OP_TAIL) ? shadow_count : pos;
            if (shadow_count < LIST_CAPACITY && slot <= shadow_count) begin
               for (i = shadow_count; i > slot; i--)
                  shadow_entries[i] = shadow_entries[i-1];
               shadow_entries[slot] = val;
               shadow_count++;
               res.ok = 1'b1;
            end
         end
         ilid_pkg::OP_DELETE: begin
            if (pos < shadow_count) begin
               for (i = pos; i + 1 < shadow_count; i++)
                  shadow_entries[i] = shadow_entries[i+1];
               shadow_count--;
               res.ok = 1'b1;
            end
         end
         default: ;
      endcase
      res.length = shadow_count[LEN_W-1:0];
   endtask

   always @(posedge clock) begin : watch
      list_result_type want;
      list_result_type got;
      if (reset) begin
         shadow_count = 0;
         pending_results.delete();
      end else begin
         // results first: none can belong to an item taken at this same edge
         if (rsp_tvalid && rsp_tready) begin
            got.read_value = rsp_tdata[VALUE_W-1:0];
            got.ok         = rsp_tdata[VALUE_W];
            got.length     = rsp_tdata[VALUE_W+LEN_W:VALUE_W+1];
            if (pending_results.size() == 0) begin
               if (fail_tally < REPORT_LIMIT)
                  $display("%0t: unexpected result read_value=%h ok=%b length=%0d",
                           $realtime, got.read_value, got.ok, got.length);
               fail_tally++;
            end else begin
               want = pending_results.pop_front();
               if (want.read_value !== got.read_value || want.ok !== got.ok ||
                   want.length !== got.length) begin
                  if (fail_tally < REPORT_LIMIT)
                     $display({"%0t: result mismatch, expected read_value=%h ok=%b ",
                               "length=%0d, got read_value=%h ok=%b length=%0d"},
                              $realtime, want.read_value, want.ok, want.length,
                              got.read_value, got.ok, got.length);
                  fail_tally++;
               end
            end
         end
         if (req_tvalid && req_tready) begin
            apply_list_op(req_tdata[OP_W-1:0], req_tdata[OP_W+POS_W-1:OP_W],
                          req_tdata[OP_W+POS_W+VALUE_W-1:OP_W+POS_W], want);
            pending_results.push_back(want);
         end
      end
      mismatches  <= fail_tally;
      outstanding <= pending_results.size();
   end

endmodule

// File: sim/tb_indexed_list_insert_delete.sv
module tb_indexed_list_insert_delete;

   localparam int OP_W             = ilid_pkg::OP_W;
   localparam int POS_W            = ilid_pkg::POS_W;
   localparam int VALUE_W          = ilid_pkg::VALUE_W;
   localparam int REQ_DATA_W       = ilid_pkg::REQ_DATA_W;
   localparam int RSP_DATA_W       = ilid_pkg::RSP_DATA_W;
   localparam int LIST_CAPACITY    = ilid_pkg::CAPACITY_DFLT;
   localparam int RESET_CYCLES     = 9;
   localparam int RANDOM_ITEMS     = 555;
   localparam int LONG_HOLD_CYCLES = 400;
   // longest quiet stretch of a correct run is an insert at the head of a
   // nearly full list plus a receiver stall
   localparam int IDLE_LIMIT       = 10000;
   localparam int SETTLE_CYCLES    = 20;
   localparam logic [OP_W-1:0]  FIRST_UNKNOWN_OP = 3'd5;
   localparam logic [OP_W-1:0]  LAST_UNKNOWN_OP  = 3'd7;
   localparam logic [POS_W-1:0] TOP_POSITION     = 11'd1024;

   logic                  clock      = 1'b0;
   logic                  reset      = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata  = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;

   int unsigned mismatches;
   int unsigned outstanding;

   // length the stimulus believes the list has, used only to aim positions
   int unsigned list_len    = 0;
   // while set, neither side idles
   logic        calm        = 1'b0;
   // each increment asks the receiver for one long hold-off
   int unsigned hold_asks   = 0;
   int unsigned holds_done  = 0;
   int unsigned ready_wait  = 0;
   int unsigned idle_cycles = 0;

   indexed_list_insert_delete uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   list_op_check list_watch (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .mismatches  (mismatches),
      .outstanding (outstanding)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Receiver: mostly ready, short stalls, a few long ones, and a long hold-off
   // whenever the stimulus asks for one.
   always @(posedge clock) begin : result_ready
      int unsigned roll;
      if (reset) begin
         rsp_tready <= 1'b0;
         ready_wait <= 0;
      end else if (hold_asks != holds_done) begin
         rsp_tready <= 1'b0;
         ready_wait <= LONG_HOLD_CYCLES;
         holds_done <= holds_done + 1;
      end else if (ready_wait > 0) begin
         rsp_tready <= 1'b0;
         ready_wait <= ready_wait - 1;
      end else if (calm) begin
         rsp_tready <= 1'b1;
      end else begin
         roll = $urandom_range(0, 99);
         if (roll < 75) begin
            rsp_tready <= 1'b1;
         end else begin
            rsp_tready <= 1'b0;
            ready_wait <= (roll < 96) ? $urandom_range(0, 3) : $urandom_range(20, 80);
         end
      end
   end

   // Count cycles in which neither channel moves an item.
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
   end

   initial begin : watchdog
      wait (idle_cycles >= IDLE_LIMIT);
      $display("tb_indexed_list_insert_delete failed");
      $finish;
   end

   // Pick the sender's gap before the next item: mostly none, a few long.
   function automatic int unsigned pick_gap();
      int unsigned roll;
      if (calm)
         return 0;
      roll = $urandom_range(0, 99);
      if (roll < 70)
         return 0;
      if (roll < 95)
         return $urandom_range(1, 3);
      return $urandom_range(20, 60);
   endfunction

   // Aim a position: usually below good_count, otherwise at or above it.
   function automatic logic [POS_W-1:0] aim_position(int unsigned good_count);
      if (good_count > 0 && ($urandom_range(0, 99) < 85 || good_count > TOP_POSITION))
         return POS_W'($urandom_range(0, good_count - 1));
      return POS_W'($urandom_range(good_count, TOP_POSITION));
   endfunction

   // Offer one item, hold it until taken, then advance the length estimate.
   task automatic send_item(input logic [OP_W-1:0] op, input logic [POS_W-1:0] pos,
                            input logic [VALUE_W-1:0] val);
      int unsigned gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {{(REQ_DATA_W-OP_W-POS_W-VALUE_W){1'b0}}, val, pos, op};
      do @(posedge clock); while (!req_tready);
      case (op)
         ilid_pkg::OP_HEAD, ilid_pkg::OP_TAIL:
            if (list_len < LIST_CAPACITY) list_len++;
         ilid_pkg::OP_INSERT:
            if (list_len < LIST_CAPACITY && pos <= list_len) list_len++;
         ilid_pkg::OP_DELETE:
            if (pos < list_len) list_len--;
         default: ;
      endcase
   endtask

   // Drop valid and wait until every expected result has come back.
   task automatic wait_until_answered();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (outstanding != 0);
   endtask

   task automatic send_random_item();
      int unsigned roll;
      roll = $urandom_range(0, 99);
      if (roll < 25)
         send_item(ilid_pkg::OP_GET, aim_position(list_len), $urandom());
      else if (roll < 35)
         send_item(ilid_pkg::OP_HEAD, POS_W'($urandom_range(0, TOP_POSITION)), $urandom());
      else if (roll < 47)
         send_item(ilid_pkg::OP_TAIL, POS_W'($urandom_range(0, TOP_POSITION)), $urandom());
      else if (roll < 65)
         send_item(ilid_pkg::OP_INSERT, aim_position(list_len + 1), $urandom());
      else if (roll < 95)
         send_item(ilid_pkg::OP_DELETE, aim_position(list_len), $urandom());
      else
         send_item(OP_W'($urandom_range(FIRST_UNKNOWN_OP, LAST_UNKNOWN_OP)),
                   POS_W'($urandom_range(0, TOP_POSITION)), $urandom());
   endtask

   initial begin : stimulus
      int unsigned n;
      int          code;

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // directed: empty list, extremes of the values, every op, bad positions
      send_item(ilid_pkg::OP_GET,    11'd0,    32'h0000_0000);   // miss on empty list
      send_item(ilid_pkg::OP_DELETE, 11'd0,    32'h0000_0000);   // bad position, empty
      send_item(ilid_pkg::OP_INSERT, 11'd1,    32'h5555_5555);   // bad position, past end
      send_item(ilid_pkg::OP_INSERT, 11'd0,    32'h8000_0000);   // insert into empty list
      send_item(ilid_pkg::OP_HEAD,   11'd2047 & TOP_POSITION, 32'h7FFF_FFFF);
      send_item(ilid_pkg::OP_TAIL,   11'd1023, 32'hFFFF_FFFF);
      send_item(ilid_pkg::OP_INSERT, 11'd3,    32'h0000_0000);   // position equal to length
      send_item(ilid_pkg::OP_INSERT, 11'd1,    32'h1234_5678);
      for (n = 0; n < 6; n++)                                    // last one misses at length
         send_item(ilid_pkg::OP_GET, POS_W'(n), 32'hFFFF_FFFF);
      send_item(ilid_pkg::OP_GET,    TOP_POSITION, 32'h0000_0000);
      send_item(ilid_pkg::OP_DELETE, TOP_POSITION, 32'h0000_0000);
      send_item(ilid_pkg::OP_INSERT, 11'd1023, 32'hAAAA_AAAA);
      for (code = FIRST_UNKNOWN_OP; code <= LAST_UNKNOWN_OP; code++)
         send_item(OP_W'(code), TOP_POSITION, 32'hDEAD_BEEF);
      send_item(ilid_pkg::OP_DELETE, 11'd0, 32'h0000_0000);      // head
      send_item(ilid_pkg::OP_DELETE, 11'd3, 32'h0000_0000);      // tail
      send_item(ilid_pkg::OP_DELETE, 11'd1, 32'h0000_0000);      // middle
      send_item(ilid_pkg::OP_GET,    11'd0, 32'h0000_0000);
      send_item(ilid_pkg::OP_GET,    11'd1, 32'h0000_0000);

      // random mix, with long hold-offs, a full pause and a stretch without gaps
      for (n = 0; n < RANDOM_ITEMS; n++) begin
         if (n == 100 || n == 350)
            hold_asks <= hold_asks + 1;
         if (n == 300)
            wait_until_answered();
         if (n == 200)
            calm <= 1'b1;
         if (n == 260)
            calm <= 1'b0;
         send_random_item();
      end

      wait_until_answered();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mismatches == 0 && outstanding == 0)
         $display("tb_indexed_list_insert_delete passed");
      else
         $display("tb_indexed_list_insert_delete failed");
      $finish;
   end

endmodule

// File: sim.f
rtl/ilid_pkg.sv
rtl/ilid_ram.sv
rtl/indexed_list_insert_delete.sv
sim/list_op_check.sv
sim/tb_indexed_list_insert_delete.sv
